[sv/hyperplane_lsh_bucket_engine_unit_assert.svh]
// assertion macros for the lsh bucket engine
`ifndef HYPERPLANE_LSH_BUCKET_ENGINE_UNIT_ASSERT_SVH
`define HYPERPLANE_LSH_BUCKET_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define HLSH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define HLSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HLSH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HLSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/hlsh_pkg.sv]
package hlsh_pkg;
    localparam int MAX_BITS        = 16;
    localparam int MAX_LENGTH      = 16;
    localparam int DEF_TABLE_SLOTS = 256;
    localparam int SIG_W           = 16;
    localparam int ACC_W           = 40;
    localparam int QDEPTH          = 4;
    localparam int QCNT_W          = $clog2(QDEPTH + 1);

    // operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_NEW   = 3'd0;
    localparam logic [2:0] ST_EXIST = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_MATCH = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    // configuration register indexes
    localparam logic CFG_SIG_BITS = 1'b0;
    localparam logic CFG_VEC_LEN  = 1'b1;

    // finished point handed from front to back
    typedef struct packed {
        logic             is_query;
        logic [SIG_W-1:0] sig;
    } t_job;

    // clamp a register write to 1..hi
    function automatic logic [4:0] clamp_reg(input logic [4:0] v, input logic [4:0] hi);
        logic [4:0] x;
        x = (v == 5'd0) ? 5'd1 : v;
        return (x > hi) ? hi : x;
    endfunction

    // number of set bits in a signature
    function automatic logic [4:0] popcnt(input logic [SIG_W-1:0] x);
        logic [4:0] c;
        c = '0;
        for (int k = 0; k < SIG_W; k++) begin
            c = c + 5'(x[k]);
        end
        return c;
    endfunction
endpackage

[sv/hlsh_if.sv]
interface hlsh_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [3:0]         plane_index;
    logic [3:0]         element_index;
    logic signed [15:0] value;
    logic               last;
    modport source(output valid, op, plane_index, element_index, value, last, input ready);
    modport sink(input valid, op, plane_index, element_index, value, last, output ready);
endinterface

interface hlsh_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [4:0]  distance;
    logic [15:0] signature;
    logic [15:0] member_count;
    modport source(output valid, status, slot, distance, signature, member_count, input ready);
    modport sink(input valid, status, slot, distance, signature, member_count, output ready);
endinterface

[sv/hlsh_front.sv]
module hlsh_front
    import hlsh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    hlsh_in_if.sink           i_in,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [4:0]        i_cfg_data,
    input  logic [QCNT_W-1:0] i_q_count,
    output logic              o_push,
    output t_job              o_job
);
    // coefficient banks, one per hyperplane, indexed by element
    logic signed [15:0] r_coef [MAX_BITS][MAX_LENGTH];
    logic [4:0] r_sig_bits, r_vec_len;

    logic r_s1_valid, r_s1_last, r_s1_query, r_s1_en;
    logic signed [15:0] r_s1_val;
    logic signed [15:0] r_s1_coef [MAX_BITS];
    logic r_s2_valid, r_s2_last, r_s2_query;
    logic signed [31:0] r_s2_prod [MAX_BITS];
    logic signed [ACC_W-1:0] r_sum [MAX_BITS];
    logic signed [ACC_W-1:0] n_sum [MAX_BITS];
    logic [SIG_W-1:0] n_sig;
    logic acc, is_elem;

    // hold off while the queue could not take every point in flight
    assign i_in.ready = (i_q_count + QCNT_W'(r_s1_valid & r_s1_last)
                         + QCNT_W'(r_s2_valid & r_s2_last)) < QCNT_W'(QDEPTH);
    assign acc     = i_in.valid && i_in.ready;
    assign is_elem = (i_in.op == OP_INSERT) || (i_in.op == OP_QUERY);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_bits <= 5'd16;
            r_vec_len  <= 5'd16;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SIG_BITS) r_sig_bits <= clamp_reg(i_cfg_data, 5'(MAX_BITS));
            else r_vec_len <= clamp_reg(i_cfg_data, 5'(MAX_LENGTH));
        end
    end

    // coefficient load
    always_ff @(posedge i_clk) begin
        if (acc && i_in.op == OP_LOAD) begin
            r_coef[i_in.plane_index][i_in.element_index] <= i_in.value;
        end
    end

    // stage 1: coefficient read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc && is_elem;
        end
        r_s1_last  <= i_in.last;
        r_s1_query <= (i_in.op == OP_QUERY);
        r_s1_en    <= {1'b0, i_in.element_index} < r_vec_len;
        r_s1_val   <= i_in.value;
        for (int p = 0; p < MAX_BITS; p++) begin
            r_s1_coef[p] <= r_coef[p][i_in.element_index];
        end
    end

    // stage 2: one multiply per hyperplane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_last  <= r_s1_last;
        r_s2_query <= r_s1_query;
        for (int p = 0; p < MAX_BITS; p++) begin
            r_s2_prod[p] <= r_s1_en ? r_s1_coef[p] * r_s1_val : 32'sd0;
        end
    end

    // accumulate and form the signature
    always_comb begin
        for (int p = 0; p < MAX_BITS; p++) begin
            n_sum[p] = r_sum[p] + {{(ACC_W-32){r_s2_prod[p][31]}}, r_s2_prod[p]};
            n_sig[p] = !n_sum[p][ACC_W-1] && (5'(p) < r_sig_bits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < MAX_BITS; p++) r_sum[p] <= '0;
        end else if (r_s2_valid) begin
            for (int p = 0; p < MAX_BITS; p++) r_sum[p] <= r_s2_last ? '0 : n_sum[p];
        end
    end

    assign o_push       = r_s2_valid && r_s2_last;
    assign o_job.is_query = r_s2_query;
    assign o_job.sig    = n_sig;
endmodule

[sv/hlsh_fifo.sv]
module hlsh_fifo
    import hlsh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_job              i_job,
    input  logic              i_pop,
    output logic              o_valid,
    output t_job              o_job,
    output logic [QCNT_W-1:0] o_count
);
    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    t_job r_buf [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_job;
    end

    assign o_valid = (r_count != '0);
    assign o_job   = r_buf[r_rp];
    assign o_count = r_count;
endmodule

[sv/hlsh_back.sv]
module hlsh_back
    import hlsh_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    hlsh_out_if.source o_out
);
    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int UW = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT, S_DONE} t_state;

    // bucket store: key in the upper half, member count in the lower
    logic [31:0] r_mem [TABLE_SLOTS];
    logic [31:0] r_rd_data;
    logic        r_wr_en;
    logic [AW-1:0] r_wr_addr;
    logic [31:0] r_wr_data;

    t_state r_state;
    logic [UW-1:0] r_used;
    logic [AW-1:0] r_idx, r_rd_idx, r_best_idx, r_hit_idx;
    logic r_rd_valid, r_rd_last, r_first, r_found, r_query;
    logic [SIG_W-1:0] r_sig;
    logic [4:0] r_best_d;
    logic [15:0] r_best_mem, r_hit_mem;
    logic [4:0] rd_dist;
    logic [15:0] hit_inc;

    assign o_pop   = (r_state == S_IDLE) && i_job_valid && !o_out.valid;
    assign rd_dist = popcnt(r_rd_data[31:16] ^ r_sig);
    assign hit_inc = (r_hit_mem == 16'hFFFF) ? r_hit_mem : r_hit_mem + 16'd1;

    // memory port: registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (r_wr_en) r_mem[r_wr_addr] <= r_wr_data;
        r_rd_data <= r_mem[r_idx];
    end

    // scan sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_wr_en     <= 1'b0;
            r_rd_valid  <= 1'b0;
            o_out.valid <= 1'b0;
        end else begin
            r_wr_en    <= 1'b0;
            r_rd_valid <= (r_state == S_SCAN);
            r_rd_idx   <= r_idx;
            r_rd_last  <= (r_idx == AW'(r_used - 1'b1));
            if (o_out.valid && o_out.ready) o_out.valid <= 1'b0;

            // compare each key as it returns from the store
            if (r_rd_valid) begin
                if (r_rd_data[31:16] == r_sig) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                    r_hit_mem <= r_rd_data[15:0];
                end
                if (r_first || rd_dist < r_best_d) begin
                    r_best_d   <= rd_dist;
                    r_best_idx <= r_rd_idx;
                    r_best_mem <= r_rd_data[15:0];
                end
                r_first <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_sig   <= i_job.sig;
                        r_query <= i_job.is_query;
                        r_idx   <= '0;
                        r_first <= 1'b1;
                        r_found <= 1'b0;
                        if (r_used == '0) begin
                            o_out.valid        <= 1'b1;
                            o_out.signature    <= i_job.sig;
                            o_out.distance     <= '0;
                            o_out.slot         <= '0;
                            if (i_job.is_query) begin
                                o_out.status       <= ST_EMPTY;
                                o_out.member_count <= '0;
                            end else begin
                                o_out.status       <= ST_NEW;
                                o_out.member_count <= 16'd1;
                                r_wr_en   <= 1'b1;
                                r_wr_addr <= '0;
                                r_wr_data <= {i_job.sig, 16'd1};
                                r_used    <= UW'(1);
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx == AW'(r_used - 1'b1)) r_state <= S_WAIT;
                    else r_idx <= r_idx + 1'b1;
                end
                S_WAIT: begin
                    if (r_rd_valid && r_rd_last) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state         <= S_IDLE;
                    o_out.valid     <= 1'b1;
                    o_out.signature <= r_sig;
                    if (r_query) begin
                        o_out.status       <= ST_MATCH;
                        o_out.slot         <= 8'(r_best_idx);
                        o_out.distance     <= r_best_d;
                        o_out.member_count <= r_best_mem;
                    end else if (r_found) begin
                        o_out.status       <= ST_EXIST;
                        o_out.slot         <= 8'(r_hit_idx);
                        o_out.distance     <= '0;
                        o_out.member_count <= hit_inc;
                        r_wr_en   <= 1'b1;
                        r_wr_addr <= r_hit_idx;
                        r_wr_data <= {r_sig, hit_inc};
                    end else if (r_used == UW'(TABLE_SLOTS)) begin
                        o_out.status       <= ST_FULL;
                        o_out.slot         <= '0;
                        o_out.distance     <= '0;
                        o_out.member_count <= '0;
                    end else begin
                        o_out.status       <= ST_NEW;
                        o_out.slot         <= 8'(r_used);
                        o_out.distance     <= '0;
                        o_out.member_count <= 16'd1;
                        r_wr_en   <= 1'b1;
                        r_wr_addr <= AW'(r_used);
                        r_wr_data <= {r_sig, 16'd1};
                        r_used    <= r_used + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[sv/hyperplane_lsh_bucket_engine_unit.sv]
// Hyperplane LSH bucket engine, one table.
// i_in carries items (valid/ready): op 0 loads one coefficient of the plane
// matrix, op 1 and op 2 stream the elements of an insert or query point.
// Config: i_cfg_we with i_cfg_index (0 signature bits, 1 vector length)
// and i_cfg_data, to be written by the user only while the block is idle;
// the block itself does not enforce this. o_out returns one result per
// point, on the element marked last. Elements and loads are taken one per
// cycle while i_in.ready is high; the multiply-accumulate pipeline registers
// the coefficient read and then the products. Each finished point goes into
// a four-entry queue; the back end then scans the stored keys one per cycle
// from the bucket memory (on an empty table the result is formed without a scan).
// A full queue holds off new items; a stalled receiver holds the result
// register and the back end stops taking points from the queue.
// Reset clears the accumulators, the bucket count and all control state;
// coefficients and bucket entries are undefined until written.
`include "hyperplane_lsh_bucket_engine_unit_assert.svh"
module hyperplane_lsh_bucket_engine_unit
    import hlsh_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hlsh_in_if.sink    i_in,
    hlsh_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [4:0] i_cfg_data
);
    logic              push, pop, q_valid;
    t_job              push_job, q_job;
    logic [QCNT_W-1:0] q_count;

    // front: coefficient store and accumulators
    hlsh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_job       (push_job)
    );

    // point queue
    hlsh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_count (q_count)
    );

    // back: bucket store and scan
    hlsh_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_out       (o_out)
    );

    `HLSH_ASSERT_IMPL(a_q_no_overflow, i_clk, i_rst_n, push && !pop, q_count < QCNT_W'(QDEPTH))
    `HLSH_ASSERT_IMPL(a_q_no_underflow, i_clk, i_rst_n, pop, q_valid)
    `HLSH_ASSERT_IMPL(a_insert_dist, i_clk, i_rst_n, o_out.valid && o_out.status != ST_MATCH, o_out.distance == 5'd0)
    `HLSH_ASSERT_NEXT(a_pop_holds_out, i_clk, i_rst_n, pop, !o_out.valid || o_out.status == ST_EMPTY || o_out.status == ST_NEW)
endmodule
